// File: design/terrain_aspect_3x3_top_defines.svh
// assertion macros for the terrain aspect block
// used by terrain_aspect_3x3_top, expects clk and rst_n in scope
`ifndef TERRAIN_ASPECT_3X3_TOP_DEFINES_SVH
`define TERRAIN_ASPECT_3X3_TOP_DEFINES_SVH

// same-cycle implication
`define TA3_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication after a fixed number of cycles
`define TA3_ASSERT_DLY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

// File: design/ta3_pkg.sv
// shared types, constants and the arctangent table for the terrain aspect block
// no dependencies
package ta3_pkg;

  localparam int ELEV_W         = 32;
  localparam int MASK_W         = 9;
  localparam int ASPECT_W       = 16;
  localparam int ELEV_BITS_DEF  = 32;
  localparam int ANGLE_ITER_DEF = 16;
  localparam int ATAN_LEN       = 24;
  localparam int NORM_BITS      = 30;
  localparam int CW             = 33;
  localparam int ZW             = 32;
  localparam int Q_W            = 14;
  localparam int CENTER_IDX     = 4;
  localparam int ROUND_SHIFT    = 16;

  localparam logic [Q_W-1:0]      Q_RIGHT    = 14'd9000;
  localparam logic [ZW-1:0]       ROUND_HALF = 32'd32768;
  localparam logic [ASPECT_W-1:0] DEG_90     = 16'd9000;
  localparam logic [ASPECT_W-1:0] DEG_270    = 16'd27000;
  localparam logic [ASPECT_W-1:0] DEG_360    = 16'd36000;

  typedef struct packed {
    logic signed [ELEV_W-1:0] elev_up_left;
    logic signed [ELEV_W-1:0] elev_up;
    logic signed [ELEV_W-1:0] elev_up_right;
    logic signed [ELEV_W-1:0] elev_left;
    logic signed [ELEV_W-1:0] elev_center;
    logic signed [ELEV_W-1:0] elev_right;
    logic signed [ELEV_W-1:0] elev_down_left;
    logic signed [ELEV_W-1:0] elev_down;
    logic signed [ELEV_W-1:0] elev_down_right;
    logic [MASK_W-1:0]        defined_mask;
  } in_word_t;

  typedef struct packed {
    logic [ASPECT_W-1:0] aspect_centideg;
    logic                result_defined;
    logic                flat_window;
  } out_word_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic defined;
    logic flat;
    logic x_neg;
    logic y_neg;
    logic q_zero;
    logic q_full;
  } side_t;

  // sign of x, sign of y
  typedef enum logic [1:0] {
    QUAD_1 = 2'b00,
    QUAD_4 = 2'b01,
    QUAD_2 = 2'b10,
    QUAD_3 = 2'b11
  } quad_t;

  // atan(2^-k) in centidegrees, q16
  function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] idx);
    logic signed [ZW-1:0] val;
    case (idx)
      5'd0:    val = 32'sd294912000;
      5'd1:    val = 32'sd174096719;
      5'd2:    val = 32'sd91987925;
      5'd3:    val = 32'sd46694507;
      5'd4:    val = 32'sd23437865;
      5'd5:    val = 32'sd11730358;
      5'd6:    val = 32'sd5866610;
      5'd7:    val = 32'sd2933484;
      5'd8:    val = 32'sd1466764;
      5'd9:    val = 32'sd733385;
      5'd10:   val = 32'sd366693;
      5'd11:   val = 32'sd183346;
      5'd12:   val = 32'sd91673;
      5'd13:   val = 32'sd45837;
      5'd14:   val = 32'sd22918;
      5'd15:   val = 32'sd11459;
      5'd16:   val = 32'sd5730;
      5'd17:   val = 32'sd2865;
      5'd18:   val = 32'sd1432;
      5'd19:   val = 32'sd716;
      5'd20:   val = 32'sd358;
      5'd21:   val = 32'sd179;
      5'd22:   val = 32'sd90;
      5'd23:   val = 32'sd45;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// File: design/terrain_aspect_3x3_top.sv
// top level of the horn aspect block: front end, arctangent cell row, back end
// depends on ta3_pkg, ta3_front, ta3_cordic_cell, ta3_back and the defines header
//
// channel  ports                      handshake
// input    start, busy, in_word       taken when start is high and busy is low
// result   out_strobe, out_word       valid for one cycle, always taken
// config   cfg_we, cfg_wdata          written when cfg_we is high
//
// one window per cycle; each taken word passes through the front end, the cell row and the back end in order
// the row of arctangent cells holds one registered cell per iteration
// reset is synchronous and clears the pipeline valid bits and scale_negative
// busy stays low, and the result side has no backpressure
`include "terrain_aspect_3x3_top_defines.svh"
module terrain_aspect_3x3_top #(
  parameter int ELEV_BITS        = ta3_pkg::ELEV_BITS_DEF,
  parameter int ANGLE_ITERATIONS = ta3_pkg::ANGLE_ITER_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ta3_pkg::in_word_t  in_word,
  output logic               out_strobe,
  output ta3_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);

  localparam int LATENCY = ANGLE_ITERATIONS + 7;

  logic scale_r;
  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= 1'b0;
    end else if (cfg_we) begin
      scale_r <= cfg_wdata;
    end
  end

  logic [ANGLE_ITERATIONS:0] chain_v;
  ta3_pkg::cordic_t          chain_st [ANGLE_ITERATIONS+1];
  ta3_pkg::side_t            chain_sd [ANGLE_ITERATIONS+1];

  ta3_front #(
    .ELEV_BITS(ELEV_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .in_word       (in_word),
    .scale_negative(scale_r),
    .head_valid    (chain_v[0]),
    .head_state    (chain_st[0]),
    .head_side     (chain_sd[0])
  );

  for (genvar k = 0; k < ANGLE_ITERATIONS; k++) begin : g_cell
    ta3_cordic_cell #(
      .K(k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (chain_v[k]),
      .in_state (chain_st[k]),
      .in_side  (chain_sd[k]),
      .out_valid(chain_v[k+1]),
      .out_state(chain_st[k+1]),
      .out_side (chain_sd[k+1])
    );
  end

  ta3_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chain_v[ANGLE_ITERATIONS]),
    .in_state  (chain_st[ANGLE_ITERATIONS]),
    .in_side   (chain_sd[ANGLE_ITERATIONS]),
    .out_strobe(out_strobe),
    .out_word  (out_word)
  );

  `TA3_ASSERT_DLY(a_word_latency, accept, LATENCY, out_strobe, "accepted word did not come out")
  `TA3_ASSERT_IMP(a_aspect_range, out_strobe, out_word.aspect_centideg < ta3_pkg::DEG_360, "aspect out of range")
  `TA3_ASSERT_IMP(a_flat_word, out_strobe && out_word.flat_window, out_word.result_defined && (out_word.aspect_centideg == ta3_pkg::DEG_270), "flat word malformed")
  `TA3_ASSERT_IMP(a_undef_word, out_strobe && !out_word.result_defined, (out_word.aspect_centideg == '0) && !out_word.flat_window, "undefined word not cleared")

endmodule

// File: design/ta3_front.sv
// front end: neighbor fill, horn gradients, magnitudes and range normalization
// depends on ta3_pkg
module ta3_front #(
  parameter int ELEV_BITS = ta3_pkg::ELEV_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  ta3_pkg::in_word_t  in_word,
  input  logic               scale_negative,
  output logic               head_valid,
  output ta3_pkg::cordic_t   head_state,
  output ta3_pkg::side_t     head_side
);

  localparam int RAW_W = (ta3_pkg::ELEV_W > ELEV_BITS) ? ta3_pkg::ELEV_W : ELEV_BITS;
  localparam int SUM_W = ELEV_BITS + 2;
  localparam int GW    = ELEV_BITS + 4;
  localparam int AW    = ELEV_BITS + 3;
  localparam int NW    = (AW > ta3_pkg::NORM_BITS) ? AW : ta3_pkg::NORM_BITS + 1;
  localparam int SW    = $clog2(NW - ta3_pkg::NORM_BITS + 1);

  // stage 1: fill and partial sums
  logic [ta3_pkg::ELEV_W-1:0]  raw  [9];
  logic [RAW_W-1:0]            wide [9];
  logic signed [ELEV_BITS-1:0] elev [9];
  logic signed [SUM_W-1:0]     term [9];
  logic signed [SUM_W-1:0]     sum_nxt [4];
  logic signed [SUM_W-1:0]     sum_r   [4];
  logic                        v1_r;
  logic                        def1_r;

  always_comb begin
    raw[0] = in_word.elev_up_left;
    raw[1] = in_word.elev_up;
    raw[2] = in_word.elev_up_right;
    raw[3] = in_word.elev_left;
    raw[4] = in_word.elev_center;
    raw[5] = in_word.elev_right;
    raw[6] = in_word.elev_down_left;
    raw[7] = in_word.elev_down;
    raw[8] = in_word.elev_down_right;
    for (int n = 0; n < 9; n++) begin
      wide[n] = RAW_W'(raw[n]);
    end
    for (int n = 0; n < 9; n++) begin
      elev[n] = in_word.defined_mask[n] ? wide[n][ELEV_BITS-1:0]
                                        : wide[ta3_pkg::CENTER_IDX][ELEV_BITS-1:0];
      term[n] = SUM_W'(elev[n]);
    end
    sum_nxt[0] = term[2] + (term[5] <<< 1) + term[8];
    sum_nxt[1] = term[0] + (term[3] <<< 1) + term[6];
    sum_nxt[2] = term[6] + (term[7] <<< 1) + term[8];
    sum_nxt[3] = term[0] + (term[1] <<< 1) + term[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    sum_r  <= sum_nxt;
    def1_r <= in_word.defined_mask[ta3_pkg::CENTER_IDX];
  end

  // stage 2: gradients, sign of scale, X = -gx and Y = gy, both negated when scale is negative
  logic signed [GW-1:0] gx_raw, gy_raw;
  logic signed [GW-1:0] bx_nxt, by_nxt;
  logic signed [GW-1:0] bx_r, by_r;
  logic                 v2_r;
  logic                 def2_r;

  always_comb begin
    gx_raw = GW'(sum_r[0]) - GW'(sum_r[1]);
    gy_raw = GW'(sum_r[2]) - GW'(sum_r[3]);
    bx_nxt = scale_negative ? gx_raw : -gx_raw;
    by_nxt = scale_negative ? -gy_raw : gy_raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    bx_r   <= bx_nxt;
    by_r   <= by_nxt;
    def2_r <= def1_r;
  end

  // stage 3: magnitudes and flat test
  logic [AW-1:0]   ax_nxt, ay_nxt;
  logic [AW-1:0]   ax3_r, ay3_r;
  ta3_pkg::side_t  side3_nxt, side3_r;
  logic            v3_r;

  always_comb begin
    ax_nxt           = bx_r[GW-1] ? AW'(-bx_r) : AW'(bx_r);
    ay_nxt           = by_r[GW-1] ? AW'(-by_r) : AW'(by_r);
    side3_nxt        = '0;
    side3_nxt.defined = def2_r;
    side3_nxt.flat   = (bx_r == '0) && (by_r == '0);
    side3_nxt.x_neg  = bx_r[GW-1];
    side3_nxt.y_neg  = by_r[GW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    ax3_r   <= ax_nxt;
    ay3_r   <= ay_nxt;
    side3_r <= side3_nxt;
  end

  // stage 4: shift needed to bring both below 2^30
  logic [NW-1:0]  ored;
  logic [SW-1:0]  sh_nxt, sh_r;
  logic [AW-1:0]  ax4_r, ay4_r;
  ta3_pkg::side_t side4_r;
  logic           v4_r;

  always_comb begin
    ored   = NW'(ax3_r | ay3_r);
    sh_nxt = '0;
    for (int b = ta3_pkg::NORM_BITS; b < NW; b++) begin
      if (ored[b]) begin
        sh_nxt = SW'(b - ta3_pkg::NORM_BITS + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    sh_r    <= sh_nxt;
    ax4_r   <= ax3_r;
    ay4_r   <= ay3_r;
    side4_r <= side3_r;
  end

  // stage 5: apply the shift and load the head of the cell row
  logic [NW-1:0]                    axs, ays;
  logic [ta3_pkg::NORM_BITS-1:0]    x0, y0;
  ta3_pkg::cordic_t                 head_nxt, head_r;
  ta3_pkg::side_t                   hside_nxt, hside_r;
  logic                             v5_r;

  always_comb begin
    axs              = NW'(ax4_r) >> sh_r;
    ays              = NW'(ay4_r) >> sh_r;
    x0               = axs[ta3_pkg::NORM_BITS-1:0];
    y0               = ays[ta3_pkg::NORM_BITS-1:0];
    head_nxt.x       = ta3_pkg::CW'(x0);
    head_nxt.y       = ta3_pkg::CW'(y0);
    head_nxt.z       = '0;
    hside_nxt        = side4_r;
    hside_nxt.q_zero = (y0 == '0);
    hside_nxt.q_full = (x0 == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    head_r  <= head_nxt;
    hside_r <= hside_nxt;
  end

  assign head_valid = v5_r;
  assign head_state = head_r;
  assign head_side  = hside_r;

endmodule

// File: design/ta3_cordic_cell.sv
// one vectoring step of the arctangent cell row, fixed shift K
// depends on ta3_pkg
module ta3_cordic_cell #(
  parameter int K = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  ta3_pkg::cordic_t  in_state,
  input  ta3_pkg::side_t    in_side,
  output logic              out_valid,
  output ta3_pkg::cordic_t  out_state,
  output ta3_pkg::side_t    out_side
);

  localparam logic signed [ta3_pkg::ZW-1:0] ATAN_K = ta3_pkg::atan_q16(5'(K));

  logic signed [ta3_pkg::CW-1:0] x, y, y_mag, xs, ys;
  logic signed [ta3_pkg::ZW-1:0] z;
  logic                          y_neg;
  ta3_pkg::cordic_t              st_nxt, st_r;
  ta3_pkg::side_t                side_r;
  logic                          valid_r;

  always_comb begin
    x        = in_state.x;
    y        = in_state.y;
    z        = in_state.z;
    y_neg    = y[ta3_pkg::CW-1];
    y_mag    = y_neg ? -y : y;
    xs       = x >>> K;
    ys       = y_mag >>> K;
    st_nxt.x = x + ys;
    st_nxt.y = y_neg ? (y + xs) : (y - xs);
    st_nxt.z = y_neg ? (z - ATAN_K) : (z + ATAN_K);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    st_r   <= st_nxt;
    side_r <= in_side;
  end

  assign out_valid = valid_r;
  assign out_state = st_r;
  assign out_side  = side_r;

endmodule

// File: design/ta3_back.sv
// back end: angle rounding, quadrant fold to compass aspect, result register
// depends on ta3_pkg
module ta3_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  ta3_pkg::cordic_t   in_state,
  input  ta3_pkg::side_t     in_side,
  output logic               out_strobe,
  output ta3_pkg::out_word_t out_word
);

  // round and clamp the first-quadrant angle, forcing it to zero or a right angle on an axis
  logic signed [ta3_pkg::ZW-1:0] z;
  logic [ta3_pkg::ZW-1:0]        z_pos, q_wide;
  logic [ta3_pkg::Q_W-1:0]       q_nxt, q_r;
  ta3_pkg::side_t                side_r;
  logic                          v1_r;

  always_comb begin
    z      = in_state.z;
    z_pos  = z[ta3_pkg::ZW-1] ? '0 : z;
    q_wide = (z_pos + ta3_pkg::ROUND_HALF) >> ta3_pkg::ROUND_SHIFT;
    if (q_wide > ta3_pkg::ZW'(ta3_pkg::Q_RIGHT)) begin
      q_nxt = ta3_pkg::Q_RIGHT;
    end else begin
      q_nxt = q_wide[ta3_pkg::Q_W-1:0];
    end
    if (in_side.q_zero) begin
      q_nxt = '0;
    end else if (in_side.q_full) begin
      q_nxt = ta3_pkg::Q_RIGHT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    q_r    <= q_nxt;
    side_r <= in_side;
  end

  // fold to compass aspect, then mark undefined and flat windows
  logic [ta3_pkg::ASPECT_W-1:0] q16, asp;
  ta3_pkg::quad_t               quad;
  ta3_pkg::out_word_t           word_nxt, word_r;
  logic                         strobe_r;

  always_comb begin
    q16  = ta3_pkg::ASPECT_W'(q_r);
    quad = ta3_pkg::quad_t'({side_r.x_neg, side_r.y_neg});
    case (quad)
      ta3_pkg::QUAD_1: asp = ta3_pkg::DEG_90 - q16;
      ta3_pkg::QUAD_2: asp = ta3_pkg::DEG_270 + q16;
      ta3_pkg::QUAD_3: asp = ta3_pkg::DEG_270 - q16;
      ta3_pkg::QUAD_4: asp = ta3_pkg::DEG_90 + q16;
      default:         asp = '0;
    endcase
    if (asp == ta3_pkg::DEG_360) begin
      asp = '0;
    end
    word_nxt.aspect_centideg = asp;
    word_nxt.result_defined  = 1'b1;
    word_nxt.flat_window     = 1'b0;
    if (!side_r.defined) begin
      word_nxt.aspect_centideg = '0;
      word_nxt.result_defined  = 1'b0;
    end else if (side_r.flat) begin
      word_nxt.aspect_centideg = ta3_pkg::DEG_270;
      word_nxt.flat_window     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_word   = word_r;

endmodule
